@@ hw/rtl/oah_pkg.sv @@
`default_nettype none

package oah_pkg;

   localparam int KEY_W              = 31;
   localparam int SLOT_W             = 6;
   localparam int DEFAULT_TABLE_SIZE = 64;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_SEARCH = 1'b1
   } req_kind_type;

   typedef enum logic {
      MODE_LINEAR    = 1'b0,
      MODE_QUADRATIC = 1'b1
   } probe_mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_MISS    = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_BAD_KEY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HOME,
      ST_PROBE
   } state_type;

   typedef struct packed {
      req_kind_type      req_type;
      logic [KEY_W-1:0]  key;
   } req_item_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot_index;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ hw/rtl/open_addressing_hash_table.sv @@
`default_nettype none

// Open-addressing hash table of nonzero keys with linear or quadratic probing.
// Request channel: an item (insert or search, plus key) is taken at a rising
// edge where start is high and busy is low. One item is worked on at a time.
// Result channel: rsp_valid is high for exactly one cycle with status and slot.
// The receiver cannot stall; every result is taken in the cycle it is shown.
// Config: csr_we/csr_wdata write the probe mode (0 linear, 1 quadratic).
// Memory: the table is one synchronous memory read once per cycle, so a
// request stays busy while it looks at slots and shows its result in the
// same cycle as busy falls. When TABLE_SIZE is not a power of two, the
// home slot comes from a reciprocal multiplication and one correcting
// subtraction, done in the ST_HOME state. A zero key is answered in the
// cycle after it is taken.
// Reset: the probe mode returns to linear and a clearing pass writes every
// slot to empty, one slot a cycle, with busy high until the pass ends.
// The next request is taken in the same cycle as the previous result shows.
module open_addressing_hash_table #(
   parameter int TABLE_SIZE = oah_pkg::DEFAULT_TABLE_SIZE
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  oah_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   output oah_pkg::rsp_item_type rsp_data,
   input  wire                   csr_we,
   input  wire                   csr_wdata
);
   import oah_pkg::*;

   localparam int AW           = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam bit SIZE_IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
   localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / TABLE_SIZE);

   logic [KEY_W-1:0] mem [TABLE_SIZE];
   logic [KEY_W-1:0] mem_rdata_ff;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [KEY_W-1:0] mem_wdata;

   state_type        state_ff, state_in;
   probe_mode_type   mode_ff, mode_in;
   req_item_type     req_ff, req_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [AW-1:0]    odd_ff, odd_in;
   logic [AW-1:0]    cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    pend_addr_ff, pend_addr_in;
   logic [AW:0]      quot_ff, quot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_ff, rsp_in;

   logic [2*KEY_W-1:0] quot_prod;
   logic [AW:0]      rem_prod;
   logic [AW:0]      rem_diff;
   logic [AW-1:0]    rem_next;
   logic [AW-1:0]    step;
   logic [AW:0]      addr_sum;
   logic [AW-1:0]    addr_next;
   logic [AW:0]      odd_sum;
   logic [AW-1:0]    odd_next;
   logic             slot_empty;
   logic             slot_match;
   logic             last_probe;

   // The quotient estimate from the reciprocal is low by at most one, so the
   // remainder lies below twice the table size and one subtraction ends it.
   // Only the low bits of the quotient matter for the remainder.
   assign quot_prod = {{KEY_W{1'b0}}, req_data.key} * {{KEY_W{1'b0}}, RECIP};

   always_comb begin
      rem_prod = quot_ff * (AW+1)'(TABLE_SIZE);
      rem_diff = req_ff.key[AW:0] - rem_prod;
      if (rem_diff >= (AW+1)'(TABLE_SIZE)) begin
         rem_next = AW'(rem_diff - (AW+1)'(TABLE_SIZE));
      end else begin
         rem_next = rem_diff[AW-1:0];
      end
   end

   // Quadratic slots advance by the odd numbers 1, 3, 5, ... taken mod size.
   always_comb begin
      step = (mode_ff == MODE_QUADRATIC) ? odd_ff : AW'(1);
      addr_sum = {1'b0, addr_ff} + {1'b0, step};
      if (addr_sum >= (AW+1)'(TABLE_SIZE)) begin
         addr_next = AW'(addr_sum - (AW+1)'(TABLE_SIZE));
      end else begin
         addr_next = addr_sum[AW-1:0];
      end
      odd_sum = {1'b0, odd_ff} + (AW+1)'(2);
      if (odd_sum >= (AW+1)'(TABLE_SIZE)) begin
         odd_next = AW'(odd_sum - (AW+1)'(TABLE_SIZE));
      end else begin
         odd_next = odd_sum[AW-1:0];
      end
   end

   assign slot_empty = (mem_rdata_ff == '0);
   assign slot_match = (mem_rdata_ff == req_ff.key);
   assign last_probe = (cnt_ff == AW'(TABLE_SIZE - 1));

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      req_in       = req_ff;
      addr_in      = addr_ff;
      odd_in       = odd_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      quot_in      = quot_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = '0;

      if (csr_we) begin
         mode_in = probe_mode_type'(csr_wdata);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (addr_ff == AW'(TABLE_SIZE - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in  = req_data;
               cnt_in  = '0;
               odd_in  = AW'(1);
               pend_in = 1'b0;
               if (req_data.key == '0) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.status     = STATUS_BAD_KEY;
                  rsp_in.slot_index = '0;
               end else if (SIZE_IS_POW2) begin
                  addr_in  = req_data.key[AW-1:0];
                  state_in = ST_PROBE;
               end else begin
                  quot_in  = quot_prod[KEY_W+AW:KEY_W];
                  state_in = ST_HOME;
               end
            end
         end
         ST_HOME: begin
            addr_in  = rem_next;
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            // The read issued this cycle is dropped if the slot in hand ends the item.
            pend_in      = 1'b1;
            pend_addr_in = addr_ff;
            addr_in      = addr_next;
            odd_in       = odd_next;
            if (pend_ff) begin
               cnt_in = cnt_ff + AW'(1);
               if (req_ff.req_type == REQ_SEARCH) begin
                  if (slot_match) begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.status     = STATUS_DONE;
                     rsp_in.slot_index = SLOT_W'(pend_addr_ff);
                     state_in          = ST_IDLE;
                  end else if (slot_empty || last_probe) begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.status     = STATUS_MISS;
                     rsp_in.slot_index = '0;
                     state_in          = ST_IDLE;
                  end
               end else begin
                  if (slot_empty) begin
                     mem_we            = 1'b1;
                     mem_waddr         = pend_addr_ff;
                     mem_wdata         = req_ff.key;
                     rsp_valid_in      = 1'b1;
                     rsp_in.status     = STATUS_DONE;
                     rsp_in.slot_index = SLOT_W'(pend_addr_ff);
                     state_in          = ST_IDLE;
                  end else if (last_probe) begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.status     = STATUS_FULL;
                     rsp_in.slot_index = '0;
                     state_in          = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         mode_ff      <= MODE_LINEAR;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      odd_ff       <= odd_in;
      cnt_ff       <= cnt_in;
      pend_addr_ff <= pend_addr_in;
      quot_ff      <= quot_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff == ST_PROBE) || $past(start && !busy)))
      else $error("result shown without an item in progress");

   a_insert_into_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE && mem_we) |->
         (req_ff.req_type == REQ_INSERT && slot_empty))
      else $error("slot written that was not an empty insert target");

   a_slot_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_DONE) |-> (rsp_data.slot_index == '0))
      else $error("nonzero slot index on a failed item");

   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |->
         (addr_ff < TABLE_SIZE && (!pend_ff || pend_addr_ff < TABLE_SIZE)))
      else $error("probe address beyond the table");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.key != '0) |=> busy)
      else $error("nonzero key accepted without starting a probe");
`endif

endmodule

`default_nettype wire
